// ===== hw/rtl/sov_pkg.sv =====
// shared types and constants of the segment overlap vector block
// no dependencies
package sov_pkg;

  // result words are this many bits wider than one coordinate
  localparam int OUT_EXTRA = 3;

  // per-item flags that travel alongside the divider
  typedef struct packed {
    logic ovl;     // projection of b overlaps a
    logic neg_ux;  // sign of first candidate x
    logic neg_uy;  // sign of first candidate y
    logic neg_vx;  // sign of second candidate x
    logic neg_vy;  // sign of second candidate y
  } sov_flags_t;

endpackage

// ===== hw/rtl/sov_front.sv =====
// front end: differences, dot products, overlap test, numerators
// depends on sov_pkg
module sov_front #(
  parameter int C = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [C-1:0]      a_start_x,
  input  logic signed [C-1:0]      a_start_y,
  input  logic signed [C-1:0]      a_end_x,
  input  logic signed [C-1:0]      a_end_y,
  input  logic signed [C-1:0]      b_start_x,
  input  logic signed [C-1:0]      b_start_y,
  input  logic signed [C-1:0]      b_end_x,
  input  logic signed [C-1:0]      b_end_y,
  output logic [3*C+3:0]           mag_ux,
  output logic [3*C+3:0]           mag_uy,
  output logic [3*C+3:0]           mag_vx,
  output logic [3*C+3:0]           mag_vy,
  output logic [2*C+1:0]           dd,
  output sov_pkg::sov_flags_t      flags
);
  import sov_pkg::*;

  localparam int DFW = C + 1;
  localparam int PRW = 2 * DFW;
  localparam int KW  = 2 * C + 3;
  localparam int PW  = 3 * C + 4;
  localparam int DW  = 2 * C + 2;

  // 0: d, 1: b0-a0, 2: b1-a0, 3: b0-a1, 4: b1-a1, 5: b1-b0
  logic signed [DFW-1:0] vx_r [6];
  logic signed [DFW-1:0] vy_r [6];
  logic signed [DFW-1:0] vx_nxt [6];
  logic signed [DFW-1:0] vy_nxt [6];
  logic signed [PRW-1:0] px_r [6];
  logic signed [PRW-1:0] py_r [6];
  logic signed [KW-1:0]  dot_r [6];
  logic signed [DFW-1:0] d2x_r, d2y_r, d3x_r, d3y_r, d4x_r, d4y_r;
  logic signed [KW-1:0]  ku_r, kv_r, ku_nxt, kv_nxt;
  logic [DW-1:0]         dd4_r, dd5_r, dd6_r;
  logic                  ovl4_r, ovl5_r, ovl_nxt;
  logic signed [PW-1:0]  pux_r, puy_r, pvx_r, pvy_r;
  logic [PW-1:0]         mux_r, muy_r, mvx_r, mvy_r;
  sov_flags_t            flg6_r;

  always_comb begin
    vx_nxt[0] = DFW'(a_end_x)   - DFW'(a_start_x);
    vy_nxt[0] = DFW'(a_end_y)   - DFW'(a_start_y);
    vx_nxt[1] = DFW'(b_start_x) - DFW'(a_start_x);
    vy_nxt[1] = DFW'(b_start_y) - DFW'(a_start_y);
    vx_nxt[2] = DFW'(b_end_x)   - DFW'(a_start_x);
    vy_nxt[2] = DFW'(b_end_y)   - DFW'(a_start_y);
    vx_nxt[3] = DFW'(b_start_x) - DFW'(a_end_x);
    vy_nxt[3] = DFW'(b_start_y) - DFW'(a_end_y);
    vx_nxt[4] = DFW'(b_end_x)   - DFW'(a_end_x);
    vy_nxt[4] = DFW'(b_end_y)   - DFW'(a_end_y);
    vx_nxt[5] = DFW'(b_end_x)   - DFW'(b_start_x);
    vy_nxt[5] = DFW'(b_end_y)   - DFW'(b_start_y);
  end

  // overlap test and candidate choice
  always_comb begin
    ovl_nxt = !(((dot_r[1] <= 0) && (dot_r[2] <= 0)) ||
                ((dot_r[3] >= 0) && (dot_r[4] >= 0)));
    if (dot_r[5] > 0) begin
      ku_nxt = dot_r[2];
      kv_nxt = dot_r[3];
    end else begin
      ku_nxt = dot_r[1];
      kv_nxt = dot_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        vx_r[j]  <= vx_nxt[j];
        vy_r[j]  <= vy_nxt[j];
        px_r[j]  <= vx_r[0] * vx_r[j];
        py_r[j]  <= vy_r[0] * vy_r[j];
        dot_r[j] <= KW'(px_r[j]) + KW'(py_r[j]);
      end
      d2x_r  <= vx_r[0];
      d2y_r  <= vy_r[0];
      d3x_r  <= d2x_r;
      d3y_r  <= d2y_r;
      d4x_r  <= d3x_r;
      d4y_r  <= d3y_r;
      ku_r   <= ku_nxt;
      kv_r   <= kv_nxt;
      dd4_r  <= dot_r[0][DW-1:0];
      ovl4_r <= ovl_nxt;
      pux_r  <= ku_r * d4x_r;
      puy_r  <= ku_r * d4y_r;
      pvx_r  <= kv_r * d4x_r;
      pvy_r  <= kv_r * d4y_r;
      dd5_r  <= dd4_r;
      ovl5_r <= ovl4_r;
      mux_r  <= pux_r[PW-1] ? PW'(-pux_r) : PW'(pux_r);
      muy_r  <= puy_r[PW-1] ? PW'(-puy_r) : PW'(puy_r);
      mvx_r  <= pvx_r[PW-1] ? PW'(-pvx_r) : PW'(pvx_r);
      mvy_r  <= pvy_r[PW-1] ? PW'(-pvy_r) : PW'(pvy_r);
      dd6_r  <= dd5_r;
      flg6_r <= '{ovl: ovl5_r, neg_ux: pux_r[PW-1], neg_uy: puy_r[PW-1],
                  neg_vx: pvx_r[PW-1], neg_vy: pvy_r[PW-1]};
    end
  end

  assign mag_ux = mux_r;
  assign mag_uy = muy_r;
  assign mag_vx = mvx_r;
  assign mag_vy = mvy_r;
  assign dd     = dd6_r;
  assign flags  = flg6_r;

endmodule

// ===== hw/rtl/sov_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// no dependencies; quotient must fit in QB bits
module sov_div #(
  parameter int NW = 52,
  parameter int DW = 34,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] low_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [DW-1:0] den_r [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [QB-1:0] low_p;
    logic [QB-1:0] quo_p;
    logic [DW-1:0] den_p;
    logic [DW:0]   trial;
    logic          qbit;

    if (i == 0) begin : g_first
      assign rem_p = num[QB+DW-1:QB];
      assign low_p = num[QB-1:0];
      assign quo_p = '0;
      assign den_p = den;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign low_p = low_r[i-1];
      assign quo_p = quo_r[i-1];
      assign den_p = den_r[i-1];
    end

    assign trial = {rem_p, low_p[QB-1]};
    assign qbit  = (trial >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= qbit ? DW'(trial - {1'b0, den_p}) : DW'(trial);
        low_r[i] <= {low_p[QB-2:0], 1'b0};
        quo_r[i] <= {quo_p[QB-2:0], qbit};
        den_r[i] <= den_p;
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

// ===== hw/rtl/sov_back.sv =====
// back end: sign restore, squared lengths, pick of the shorter vector
// depends on sov_pkg
module sov_back #(
  parameter int QB = 17,
  parameter int OW = 19
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [QB-1:0]        q_ux,
  input  logic [QB-1:0]        q_uy,
  input  logic [QB-1:0]        q_vx,
  input  logic [QB-1:0]        q_vy,
  input  sov_pkg::sov_flags_t  flags,
  output logic                 overlaps,
  output logic signed [OW-1:0] push_x,
  output logic signed [OW-1:0] push_y
);
  import sov_pkg::*;

  localparam int SW = QB + 1;
  localparam int LW = 2 * SW + 1;

  logic signed [SW-1:0]   ux_r, uy_r, vx_r, vy_r;
  logic signed [SW-1:0]   ux2_r, uy2_r, vx2_r, vy2_r;
  logic signed [2*SW-1:0] sux_r, suy_r, svx_r, svy_r;
  logic                   ovl1_r, ovl2_r;
  logic signed [LW-1:0]   len_u, len_v;
  logic                   pick_v;
  logic                   ovl_r;
  logic signed [OW-1:0]   px_r, py_r;

  function automatic logic signed [SW-1:0] apply_sign(logic [QB-1:0] m, logic neg);
    logic signed [SW-1:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

  assign len_u  = LW'(sux_r) + LW'(suy_r);
  assign len_v  = LW'(svx_r) + LW'(svy_r);
  assign pick_v = (len_v < len_u);

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r   <= apply_sign(q_ux, flags.neg_ux);
      uy_r   <= apply_sign(q_uy, flags.neg_uy);
      vx_r   <= apply_sign(q_vx, flags.neg_vx);
      vy_r   <= apply_sign(q_vy, flags.neg_vy);
      ovl1_r <= flags.ovl;
      sux_r  <= ux_r * ux_r;
      suy_r  <= uy_r * uy_r;
      svx_r  <= vx_r * vx_r;
      svy_r  <= vy_r * vy_r;
      ux2_r  <= ux_r;
      uy2_r  <= uy_r;
      vx2_r  <= vx_r;
      vy2_r  <= vy_r;
      ovl2_r <= ovl1_r;
      // projection is never longer than its source vector, so it always fits
      ovl_r  <= ovl2_r;
      if (!ovl2_r) begin
        px_r <= '0;
        py_r <= '0;
      end else if (pick_v) begin
        px_r <= OW'(vx2_r);
        py_r <= OW'(vy2_r);
      end else begin
        px_r <= OW'(ux2_r);
        py_r <= OW'(uy2_r);
      end
    end
  end

  assign overlaps = ovl_r;
  assign push_x   = px_r;
  assign push_y   = py_r;

endmodule

// ===== hw/rtl/segment_overlap_vector.sv =====
// top level of the segment overlap vector block
// depends on sov_pkg, sov_front, sov_div, sov_back
//
// usage
//   input channel: one word per segment pair, a and b endpoints as signed
//   fixed point coordinates, taken when in_valid and in_ready are both high
//   result channel: one word per input word, overlap flag plus the shorter
//   push vector, offered on out_valid until out_ready takes it
// pipeline and throughput
//   the pipeline holds six front stages, one divider stage per quotient
//   bit and three back stages
//   one word per cycle is taken while the result side keeps up; the four
//   divides run as fully pipelined restoring dividers
// reset
//   rst_n clears the valid bits of every stage; payload registers are not
//   cleared and nothing is shown on the result side until new words arrive
// stall
//   when out_ready is low with a result waiting, the whole pipeline freezes
//   and in_ready drops in the same cycle; nothing is lost or repeated
module segment_overlap_vector #(
  parameter int COORD_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [COORD_BITS-1:0]                  in_a_start_x,
  input  logic signed [COORD_BITS-1:0]                  in_a_start_y,
  input  logic signed [COORD_BITS-1:0]                  in_a_end_x,
  input  logic signed [COORD_BITS-1:0]                  in_a_end_y,
  input  logic signed [COORD_BITS-1:0]                  in_b_start_x,
  input  logic signed [COORD_BITS-1:0]                  in_b_start_y,
  input  logic signed [COORD_BITS-1:0]                  in_b_end_x,
  input  logic signed [COORD_BITS-1:0]                  in_b_end_y,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic                                          out_overlaps,
  output logic signed [COORD_BITS+sov_pkg::OUT_EXTRA-1:0] out_push_x,
  output logic signed [COORD_BITS+sov_pkg::OUT_EXTRA-1:0] out_push_y
);
  import sov_pkg::*;

  localparam int QB  = COORD_BITS + 1;      // quotient magnitude bits
  localparam int PW  = 3 * COORD_BITS + 4;  // numerator width
  localparam int DW  = 2 * COORD_BITS + 2;  // divisor width
  localparam int OW  = COORD_BITS + OUT_EXTRA;
  localparam int LAT = 6 + QB + 3;

  logic             adv;
  logic [LAT-1:0]   vld_r;
  logic [PW-1:0]    mag_ux, mag_uy, mag_vx, mag_vy;
  logic [DW-1:0]    dd;
  logic [QB-1:0]    q_ux, q_uy, q_vx, q_vy;
  sov_flags_t       flg_front;
  sov_flags_t       flg_r [QB];

  // the pipeline moves as one whenever the last stage is empty or taken
  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  sov_front #(.C(COORD_BITS)) u_front (
    .clk       (clk),
    .en        (adv),
    .a_start_x (in_a_start_x),
    .a_start_y (in_a_start_y),
    .a_end_x   (in_a_end_x),
    .a_end_y   (in_a_end_y),
    .b_start_x (in_b_start_x),
    .b_start_y (in_b_start_y),
    .b_end_x   (in_b_end_x),
    .b_end_y   (in_b_end_y),
    .mag_ux    (mag_ux),
    .mag_uy    (mag_uy),
    .mag_vx    (mag_vx),
    .mag_vy    (mag_vy),
    .dd        (dd),
    .flags     (flg_front)
  );

  // four divides by the squared length of a, one per candidate push component
  sov_div #(.NW(PW), .DW(DW), .QB(QB)) u_div_ux (
    .clk (clk), .en (adv), .num (mag_ux), .den (dd), .quo (q_ux)
  );
  sov_div #(.NW(PW), .DW(DW), .QB(QB)) u_div_uy (
    .clk (clk), .en (adv), .num (mag_uy), .den (dd), .quo (q_uy)
  );
  sov_div #(.NW(PW), .DW(DW), .QB(QB)) u_div_vx (
    .clk (clk), .en (adv), .num (mag_vx), .den (dd), .quo (q_vx)
  );
  sov_div #(.NW(PW), .DW(DW), .QB(QB)) u_div_vy (
    .clk (clk), .en (adv), .num (mag_vy), .den (dd), .quo (q_vy)
  );

  // flags ride alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      flg_r[0] <= flg_front;
      for (int i = 1; i < QB; i++) begin
        flg_r[i] <= flg_r[i-1];
      end
    end
  end

  sov_back #(.QB(QB), .OW(OW)) u_back (
    .clk      (clk),
    .en       (adv),
    .q_ux     (q_ux),
    .q_uy     (q_uy),
    .q_vx     (q_vx),
    .q_vy     (q_vy),
    .flags    (flg_r[QB-1]),
    .overlaps (out_overlaps),
    .push_x   (out_push_x),
    .push_y   (out_push_y)
  );

endmodule

// ===== hw/rtl/sov_chk.sv =====
// port level checks of segment_overlap_vector, attached by bind
// depends on segment_overlap_vector
module sov_chk #(
  parameter int OUT_W = 19
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_overlaps,
  input logic signed [OUT_W-1:0] out_push_x,
  input logic signed [OUT_W-1:0] out_push_y
);

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_push_x) &&
    $stable(out_push_y) && $stable(out_overlaps))
    else $error("result word changed while stalled");

  // a miss carries a zero push vector
  a_zero_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overlaps |-> out_push_x == 0 && out_push_y == 0)
    else $error("push vector not zero without overlap");

  // the input side is only held back by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result stall");

endmodule

bind segment_overlap_vector sov_chk #(.OUT_W(COORD_BITS + sov_pkg::OUT_EXTRA)) u_sov_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_overlaps (out_overlaps),
  .out_push_x   (out_push_x),
  .out_push_y   (out_push_y)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the segment overlap vector block
// depends on sov_pkg and segment_overlap_vector; predicts each result in wide
// signed arithmetic and compares it field by field with the block's output
`timescale 1ns / 1ps

module testbench;
  import sov_pkg::*;

  localparam int CW = 16;
  localparam int OW = CW + OUT_EXTRA;
  localparam int N_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] push_t;
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t asx, asy, aex, aey, bsx, bsy, bex, bey;
  } pair_t;

  typedef struct packed {
    logic  ovl;
    push_t px;
    push_t py;
  } push_res_t;

  // directed rows; chk set where the expected result is typed in
  typedef struct packed {
    pair_t     p;
    logic      chk;
    push_res_t res;
  } row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_a_start_x = '0, in_a_start_y = '0, in_a_end_x = '0, in_a_end_y = '0;
  coord_t in_b_start_x = '0, in_b_start_y = '0, in_b_end_x = '0, in_b_end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_overlaps;
  push_t  out_push_x, out_push_y;

  push_res_t expected_pushes[$];
  int        n_errors = 0;
  longint    cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  segment_overlap_vector #(.COORD_BITS(CW)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_a_start_x(in_a_start_x),
    .in_a_start_y(in_a_start_y),
    .in_a_end_x  (in_a_end_x),
    .in_a_end_y  (in_a_end_y),
    .in_b_start_x(in_b_start_x),
    .in_b_start_y(in_b_start_y),
    .in_b_end_x  (in_b_end_x),
    .in_b_end_y  (in_b_end_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_overlaps(out_overlaps),
    .out_push_x  (out_push_x),
    .out_push_y  (out_push_y)
  );

  always #5 clk = ~clk;

  // clamp to the signed result width
  function automatic push_t clamp_push(wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (OW - 1)) - 1;
    lo = -(wide_t'(1) <<< (OW - 1));
    if (v > hi) return push_t'(hi);
    if (v < lo) return push_t'(lo);
    return push_t'(v);
  endfunction

  // one component of the projection of p onto d, truncated toward zero
  function automatic wide_t proj_comp(wide_t k, wide_t dc, wide_t dd);
    return (k * dc) / dd;
  endfunction

  function automatic push_res_t predict_push(pair_t p);
    wide_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, dx, dy, dd;
    wide_t ku, kv, ux, uy, vx, vy;
    push_res_t r;
    ax0 = p.asx; ay0 = p.asy; ax1 = p.aex; ay1 = p.aey;
    bx0 = p.bsx; by0 = p.bsy; bx1 = p.bex; by1 = p.bey;
    r = '0;
    dx = ax1 - ax0;
    dy = ay1 - ay0;
    // both b ends behind the start of a
    if (dx * (bx0 - ax0) + dy * (by0 - ay0) <= 0 &&
        dx * (bx1 - ax0) + dy * (by1 - ay0) <= 0) return r;
    // both b ends past the end of a
    if (-dx * (bx0 - ax1) - dy * (by0 - ay1) <= 0 &&
        -dx * (bx1 - ax1) - dy * (by1 - ay1) <= 0) return r;
    dd = dx * dx + dy * dy;
    if ((bx1 - bx0) * dx + (by1 - by0) * dy > 0) begin
      ku = (bx1 - ax0) * dx + (by1 - ay0) * dy;
      kv = (bx0 - ax1) * dx + (by0 - ay1) * dy;
    end else begin
      ku = (bx0 - ax0) * dx + (by0 - ay0) * dy;
      kv = (bx1 - ax1) * dx + (by1 - ay1) * dy;
    end
    ux = proj_comp(ku, dx, dd); uy = proj_comp(ku, dy, dd);
    vx = proj_comp(kv, dx, dd); vy = proj_comp(kv, dy, dd);
    r.ovl = 1'b1;
    if (vx * vx + vy * vy < ux * ux + uy * uy) begin
      r.px = clamp_push(vx); r.py = clamp_push(vy);
    end else begin
      r.px = clamp_push(ux); r.py = clamp_push(uy);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    n_errors++;
  endtask

  // offer one word and hold it until taken; random idle first
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_a_start_x <= p.asx; in_a_start_y <= p.asy;
    in_a_end_x   <= p.aex; in_a_end_y   <= p.aey;
    in_b_start_x <= p.bsx; in_b_start_y <= p.bsy;
    in_b_end_x   <= p.bex; in_b_end_y   <= p.bey;
    expected_pushes.push_back(predict_push(p));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0:       return coord_t'($urandom_range(7) - 4);
      1:       return coord_t'($urandom_range(1) ? 16'sh7fff - $urandom_range(3)
                                                 : 16'sh8000 + $urandom_range(3));
      2:       return coord_t'($urandom_range(4095) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.asx = rand_coord(); p.asy = rand_coord();
    p.aex = rand_coord(); p.aey = rand_coord();
    // mostly place b near a so the overlap path is well exercised
    if ($urandom_range(3) != 0) begin
      p.bsx = p.asx + coord_t'($urandom_range(255) - 128);
      p.bsy = p.asy + coord_t'($urandom_range(255) - 128);
      p.bex = p.aex + coord_t'($urandom_range(255) - 128);
      p.bey = p.aey + coord_t'($urandom_range(255) - 128);
      if ($urandom_range(1)) begin
        {p.bsx, p.bex} = {p.bex, p.bsx};
        {p.bsy, p.bey} = {p.bey, p.bsy};
      end
    end else begin
      p.bsx = rand_coord(); p.bsy = rand_coord();
      p.bex = rand_coord(); p.bey = rand_coord();
    end
    if ($urandom_range(19) == 0) begin
      // zero-length a
      p.aex = p.asx; p.aey = p.asy;
    end
    return p;
  endfunction

  // receiver: stalls at random, checks against the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_pushes.size() == 0) begin
          report_mismatch("unexpected word, overlaps", out_overlaps, 0);
        end else begin
          push_res_t w;
          w = expected_pushes.pop_front();
          if (out_overlaps !== w.ovl) report_mismatch("overlaps", out_overlaps, w.ovl);
          if (out_push_x !== w.px) report_mismatch("push_x", out_push_x, w.px);
          if (out_push_y !== w.py) report_mismatch("push_y", out_push_y, w.py);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    pair_t p;
    int    waited;
    // zero-length a: no overlap
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5},
                     1'b1, '{1'b0, 19'sd0, 19'sd0}});
    // b wholly behind a's start
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd100, 16'sd0, -16'sd50, 16'sd3, -16'sd1, 16'sd9},
                     1'b1, '{1'b0, 19'sd0, 19'sd0}});
    // b wholly past a's end, touching counts as no overlap
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd100, 16'sd0, 16'sd300, 16'sd7},
                     1'b1, '{1'b0, 19'sd0, 19'sd0}});
    // same direction along x: u = 60-0 = 60, v = 40-100 = -60, tie picks u
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd40, 16'sd9, 16'sd60, -16'sd9},
                     1'b1, '{1'b1, 19'sd60, 19'sd0}});
    // opposite direction: u = 60-0 = 60, v = 40-100 = -60, tie picks u
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd60, 16'sd0, 16'sd40, 16'sd0},
                     1'b1, '{1'b1, 19'sd60, 19'sd0}});
    // extremes of the coordinates, predicted
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                       16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000,
                       16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                       16'sh0000, 16'sh0000, 16'sh0001, 16'shffff}, 1'b0, '0});
    // long diagonal b across a short diagonal a
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8001, 16'sh8001,
                       16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000,
                       16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, '0});
    rows.push_back('{'{16'shffff, 16'shffff, 16'shffff, 16'sh7fff,
                       16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555}, 1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    out_ready <= 1'b1;

    // directed rows, no idling
    foreach (rows[i]) begin
      send_pair(rows[i].p);
      if (rows[i].chk) begin
        // replace the prediction with the typed-in value
        void'(expected_pushes.pop_back());
        expected_pushes.push_back(rows[i].res);
      end
    end

    // random phases: free run, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 80 : (ph == 3) ? 21 : 0;
      recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 21 : 0;
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        p = rand_pair();
        send_pair(p);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (expected_pushes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (n_errors == 0 && expected_pushes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sov_pkg.sv
hw/rtl/sov_front.sv
hw/rtl/sov_div.sv
hw/rtl/sov_back.sv
hw/rtl/segment_overlap_vector.sv
hw/rtl/sov_chk.sv
tb/sv/testbench.sv
